// ===== sv/arpc_pkg.sv =====
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int DEF_ENTRIES = 8;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int SLOT_W      = 3;

  localparam logic FUNC_LEARN  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_REPLACE = 2'd3
  } kind_t;

endpackage

// ===== sv/arpc_match.sv =====
`timescale 1ns / 1ps
module arpc_match import arpc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0] valid,
  input  logic [IP_W-1:0]    ip_tab [ENTRIES],
  input  logic [IP_W-1:0]    key_ip,
  output logic               hit,
  output logic [IDX_W-1:0]   hit_idx,
  output logic               free,
  output logic [IDX_W-1:0]   free_idx
);

  logic [ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (ip_tab[i] == key_ip);
    end
  end

  // lowest index wins: scan from the top so lower entries override
  always_comb begin
    hit      = |match;
    free     = ~&valid;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/arpc_table.sv =====
`timescale 1ns / 1ps
module arpc_table import arpc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic               wr_new,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [IP_W-1:0]    wr_ip,
  input  logic [MAC_W-1:0]   wr_mac,
  input  logic               ptr_adv,
  output logic [ENTRIES-1:0] valid,
  output logic [IP_W-1:0]    ip_tab [ENTRIES],
  output logic [MAC_W-1:0]   mac_tab [ENTRIES],
  output logic [IDX_W-1:0]   ptr
);

  logic [ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]    ip_r [ENTRIES];
  logic [MAC_W-1:0]   mac_r [ENTRIES];
  logic [IDX_W-1:0]   ptr_r;
  logic [IDX_W-1:0]   ptr_nxt;

  always_comb begin
    ptr_nxt = ptr_r;
    if (ptr_adv) begin
      if (ptr_r == IDX_W'(ENTRIES - 1)) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      if (wr_en && wr_new) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mac_r[wr_idx] <= wr_mac;
      if (wr_new) begin
        ip_r[wr_idx] <= wr_ip;
      end
    end
  end

  assign valid   = valid_r;
  assign ip_tab  = ip_r;
  assign mac_tab = mac_r;
  assign ptr     = ptr_r;

endmodule

// ===== sv/arp_cache_round_robin_core.sv =====
`timescale 1ns / 1ps
// IPv4-to-MAC cache, fully associative, round-robin replacement when full.
// busy stays low: one item is taken every cycle, and its result appears on
// the out_ ports with out_valid high for exactly one cycle, once the item
// has passed through the input registers and then the result registers.
// The receiver cannot stall, so each result must be captured in that cycle.
// The rate is set by the combinational parallel compare of the key against
// every entry between the input and result registers; items in flight see
// the table as left by the item before.
module arp_cache_round_robin_core import arpc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [IP_W-1:0]   in_ip_addr,
  input  logic [MAC_W-1:0]  in_mac_addr,
  output logic              out_valid,
  output logic              out_found,
  output logic [MAC_W-1:0]  out_mac_out,
  output logic [SLOT_W-1:0] out_slot,
  output logic [1:0]        out_learn_kind
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic               vld_r;
  logic               func_r;
  logic [IP_W-1:0]    ip_r;
  logic [MAC_W-1:0]   mac_r;

  logic [ENTRIES-1:0] valid;
  logic [IP_W-1:0]    ip_tab [ENTRIES];
  logic [MAC_W-1:0]   mac_tab [ENTRIES];
  logic [IDX_W-1:0]   ptr;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               free;
  logic [IDX_W-1:0]   free_idx;

  logic               wr_en;
  logic               wr_new;
  logic [IDX_W-1:0]   wr_idx;
  logic               ptr_adv;

  logic               found_nxt;
  logic [MAC_W-1:0]   mac_out_nxt;
  logic [IDX_W-1:0]   idx_nxt;
  kind_t              kind_nxt;

  logic               out_valid_r;
  logic               found_r;
  logic [MAC_W-1:0]   mac_out_r;
  logic [SLOT_W-1:0]  slot_r;
  kind_t              kind_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= in_func;
      ip_r   <= in_ip_addr;
      mac_r  <= in_mac_addr;
    end
  end

  arpc_match #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_match (
    .valid    (valid),
    .ip_tab   (ip_tab),
    .key_ip   (ip_r),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .free     (free),
    .free_idx (free_idx)
  );

  always_comb begin
    wr_en       = 1'b0;
    wr_new      = 1'b0;
    wr_idx      = hit_idx;
    ptr_adv     = 1'b0;
    found_nxt   = 1'b0;
    mac_out_nxt = '0;
    idx_nxt     = '0;
    kind_nxt    = KIND_LOOKUP;
    if (func_r == FUNC_LOOKUP) begin
      if (hit) begin
        found_nxt   = 1'b1;
        mac_out_nxt = mac_tab[hit_idx];
        idx_nxt     = hit_idx;
      end
    end else if (hit) begin
      wr_en     = vld_r;
      found_nxt = 1'b1;
      idx_nxt   = hit_idx;
      kind_nxt  = KIND_REFRESH;
    end else if (free) begin
      wr_en    = vld_r;
      wr_new   = 1'b1;
      wr_idx   = free_idx;
      idx_nxt  = free_idx;
      kind_nxt = KIND_FILL;
    end else begin
      wr_en    = vld_r;
      wr_new   = 1'b1;
      wr_idx   = ptr;
      ptr_adv  = vld_r;
      idx_nxt  = ptr;
      kind_nxt = KIND_REPLACE;
    end
  end

  arpc_table #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_new  (wr_new),
    .wr_idx  (wr_idx),
    .wr_ip   (ip_r),
    .wr_mac  (mac_r),
    .ptr_adv (ptr_adv),
    .valid   (valid),
    .ip_tab  (ip_tab),
    .mac_tab (mac_tab),
    .ptr     (ptr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      found_r   <= found_nxt;
      mac_out_r <= mac_out_nxt;
      slot_r    <= SLOT_W'(idx_nxt);
      kind_r    <= kind_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_mac_out    = mac_out_r;
  assign out_slot       = slot_r;
  assign out_learn_kind = kind_r;

endmodule

// ===== tb/tb_arp_cache_round_robin_core.sv =====
`timescale 1ns / 1ps
module tb_arp_cache_round_robin_core;
  import arpc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_SIZE  = 12;

  typedef struct packed {
    logic              found;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
    kind_t             kind;
  } arp_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_func;
  logic [IP_W-1:0]   in_ip_addr;
  logic [MAC_W-1:0]  in_mac_addr;
  logic              out_valid;
  logic              out_found;
  logic [MAC_W-1:0]  out_mac_out;
  logic [SLOT_W-1:0] out_slot;
  logic [1:0]        out_learn_kind;

  logic              tbl_valid [DEF_ENTRIES];
  logic [IP_W-1:0]   tbl_ip    [DEF_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac   [DEF_ENTRIES];
  int                victim_ptr;

  arp_result_t       pending_results [$];
  logic [IP_W-1:0]   ip_pool [POOL_SIZE];
  int                fail_count;
  int                idle_cycles;

  arp_cache_round_robin_core #(
    .ENTRIES(DEF_ENTRIES)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_ip_addr    (in_ip_addr),
    .in_mac_addr   (in_mac_addr),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_mac_out   (out_mac_out),
    .out_slot      (out_slot),
    .out_learn_kind(out_learn_kind)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic arp_result_t arp_table_access(input logic func, input logic [IP_W-1:0] ip,
                                                   input logic [MAC_W-1:0] mac);
    arp_result_t res;
    int          hit;
    int          idx;
    res = '{found: 1'b0, mac: '0, slot: '0, kind: KIND_LOOKUP};
    hit = DEF_ENTRIES;
    for (int i = DEF_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_ip[i] == ip) hit = i;
    end
    if (func == FUNC_LOOKUP) begin
      if (hit < DEF_ENTRIES) begin
        res.found = 1'b1;
        res.mac   = tbl_mac[hit];
        res.slot  = hit[SLOT_W-1:0];
      end
    end else if (hit < DEF_ENTRIES) begin
      tbl_mac[hit] = mac;
      res.found    = 1'b1;
      res.slot     = hit[SLOT_W-1:0];
      res.kind     = KIND_REFRESH;
    end else begin
      idx = DEF_ENTRIES;
      for (int i = DEF_ENTRIES - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) idx = i;
      end
      if (idx < DEF_ENTRIES) begin
        res.kind = KIND_FILL;
      end else begin
        idx        = victim_ptr % DEF_ENTRIES;
        victim_ptr = (idx + 1) % DEF_ENTRIES;
        res.kind   = KIND_REPLACE;
      end
      tbl_ip[idx]    = ip;
      tbl_mac[idx]   = mac;
      tbl_valid[idx] = 1'b1;
      res.slot       = idx[SLOT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  task automatic send_item(input logic func, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_func     <= func;
    in_ip_addr  <= ip;
    in_mac_addr <= mac;
    do @(posedge clk); while (busy);
    pending_results.push_back(arp_table_access(func, ip, mac));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_lookup();
    send_item(FUNC_LOOKUP, 32'h0000_0000, {MAC_W{1'b1}}, 0);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 0);
  endtask

  task automatic test_fill_and_refresh();
    send_item(FUNC_LEARN, 32'h0000_0000, 48'h0, 0);
    send_item(FUNC_LEARN, 32'hFFFF_FFFF, {MAC_W{1'b1}}, 0);
    send_item(FUNC_LEARN, 32'hAAAA_AAAA, 48'h5555_5555_5555, 0);
    send_item(FUNC_LEARN, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 0);
    send_item(FUNC_LEARN, 32'hC0A8_0001, 48'h0200_0000_0001, 0);
    send_item(FUNC_LEARN, 32'h0A00_0001, 48'h8000_0000_0000, 0);
    send_item(FUNC_LEARN, 32'h8000_0000, 48'h0000_0000_0001, 0);
    send_item(FUNC_LEARN, 32'h0000_0001, 48'h1234_5678_9ABC, 0);
    send_item(FUNC_LOOKUP, 32'h0000_0000, {MAC_W{1'b1}}, 0);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 0);
    send_item(FUNC_LEARN, 32'hFFFF_FFFF, 48'hDEAD_BEEF_CAFE, 0);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 0);
  endtask

  task automatic test_round_robin_replace();
    send_item(FUNC_LEARN, 32'h0101_0101, 48'h0101_0101_0101, 0);
    send_item(FUNC_LEARN, 32'h0202_0202, 48'h0202_0202_0202, 0);
    send_item(FUNC_LEARN, 32'h0303_0303, 48'h0303_0303_0303, 0);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 48'h0, 0);
    send_item(FUNC_LOOKUP, 32'h0202_0202, 48'h0, 0);
    for (int i = 4; i <= 9; i++) begin
      send_item(FUNC_LEARN, {4{i[7:0]}}, {6{i[7:0]}}, 0);
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int               block_pct;
    logic             func;
    logic [IP_W-1:0]  ip;
    block_pct = idle_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 50 == 0) begin
        block_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
        if ($urandom_range(0, 1) == 0) begin
          for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
        end
      end
      func = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else ip = $urandom;
      send_item(func, ip, rand_mac(), block_pct);
    end
  endtask

  always @(posedge clk) begin
    arp_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: found=%0b mac=%h slot=%0d kind=%0d",
                                       out_found, out_mac_out, out_slot, out_learn_kind);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_found !== exp_res.found || out_mac_out !== exp_res.mac ||
            out_slot !== exp_res.slot || out_learn_kind !== exp_res.kind) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp found=%0b mac=%h slot=%0d kind=%0d", exp_res.found,
                     exp_res.mac, exp_res.slot, exp_res.kind);
            $display("          got found=%0b mac=%h slot=%0d kind=%0d", out_found,
                     out_mac_out, out_slot, out_learn_kind);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = FUNC_LEARN;
    in_ip_addr  = '0;
    in_mac_addr = '0;
    fail_count  = 0;
    idle_cycles = 0;
    victim_ptr  = 0;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
    end
    for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lookup();
    test_fill_and_refresh();
    test_round_robin_replace();
    drain_results();
    test_random_traffic(600, 0);
    drain_results();
    test_random_traffic(600, 48);
    drain_results();
    test_random_traffic(500, 21);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
